// ----- hdl/gmoc_pkg.sv -----
// ============================================================================
// gmoc_pkg
// Shared constants, types and helpers for the greedy-match object counter.
// ============================================================================
`default_nettype none

package gmoc_pkg;

    localparam int MAX_OBJECTS = 16;
    localparam int IDX_W       = $clog2(MAX_OBJECTS);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int PAIR_CAP    = MAX_OBJECTS * MAX_OBJECTS;
    localparam int DRAIN_W     = $clog2(PAIR_CAP + 1);

    localparam int COORD_W     = 16;
    localparam int ENTRY_W     = 3 * COORD_W;
    localparam int SQR_W       = 2 * COORD_W;
    localparam int RAD_W       = SQR_W + 2;
    localparam int ROOT_W      = COORD_W + 1;
    localparam int DIST_W      = 18;
    localparam int KEY_W       = DIST_W + 2 * IDX_W;

    localparam int COUNT_W     = 32;
    localparam int THR_W       = 18;
    localparam int THRESHOLD_PIXELS = 100;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(THRESHOLD_PIXELS * 16);

    typedef logic [KEY_W-1:0] gmoc_key_t;

    typedef struct packed {
        logic ins;
        logic shf;
    } gmoc_ctl_t;

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/greedy_match_object_counter.sv -----
// ============================================================================
// greedy_match_object_counter
// Counts objects across frames by greedy nearest matching of detections.
// ============================================================================
// A detection is taken in the idle state. An end-of-frame transaction returns
// at once when the frame needs no matching (first frame, empty frame, empty
// previous list). Otherwise every previous/current pair passes through list
// read, differences, squares, sum, the bit-serial square root and insertion
// into the sorting chain, the chain then drains, and the matching pass pops
// one pair per cycle until the chain is empty, after which the frame closes.
`default_nettype none

module greedy_match_object_counter
    import gmoc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [ENTRY_W-1:0] s_tdata,  // center_x, center_y, frame_value
    input  wire logic               s_tuser,  // kind
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [COUNT_W-1:0]      m_tdata,  // object_count
    output logic                    m_tuser,  // dropped
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [THR_W-1:0]   cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_READ  = 10'b0000000010,
        ST_DIFF  = 10'b0000000100,
        ST_MUL   = 10'b0000001000,
        ST_SUM   = 10'b0000010000,
        ST_SQRT  = 10'b0000100000,
        ST_INS   = 10'b0001000000,
        ST_DRAIN = 10'b0010000000,
        ST_MATCH = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    p_reg;
    logic [IDX_W-1:0]    c_reg;
    logic [DRAIN_W-1:0]  drain_reg;
    logic [SIZE_W-1:0]   cur_size_reg;
    logic [SIZE_W-1:0]   prev_size_reg;
    logic                bank_reg;
    logic                primed_reg;
    logic                ovf_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [MAX_OBJECTS-1:0] used_p_reg;
    logic [MAX_OBJECTS-1:0] used_c_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                out_vld_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_drop_reg;

    logic [ENTRY_W-1:0]  list_mem [2 * (2 ** IDX_W)];
    logic [ENTRY_W-1:0]  rd_prev_reg;
    logic [ENTRY_W-1:0]  rd_cur_reg;
    logic [COORD_W-1:0]  dx_reg;
    logic [COORD_W-1:0]  dy_reg;
    logic [COORD_W-1:0]  df_reg;
    logic [SQR_W-1:0]    sqx_reg;
    logic [SQR_W-1:0]    sqy_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [RAD_W-1:0]    root_reg;
    logic [RAD_W-1:0]    bit_reg;

    logic                in_acc;
    logic                det_acc;
    logic                eof_acc;
    logic                eof_quick;
    logic                out_load;
    logic                room;
    logic [RAD_W-1:0]    trial;
    logic                trial_ge;
    logic                last_c;
    logic                last_p;
    logic [DIST_W-1:0]   pair_dist;
    gmoc_key_t           new_key;
    gmoc_ctl_t           sort_ctl;
    gmoc_key_t           head_key;
    logic                head_vld;
    logic [IDX_W-1:0]    head_p;
    logic [IDX_W-1:0]    head_c;
    logic [DIST_W-1:0]   head_d;
    logic                head_skip;
    logic [COUNT_W-1:0]  quick_count;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!s_tuser || !out_vld_reg || m_tready);
    assign in_acc    = s_tvalid && s_tready;
    assign det_acc   = in_acc && !s_tuser;
    assign eof_acc   = in_acc && s_tuser;
    assign room      = (cur_size_reg < SIZE_W'(MAX_OBJECTS));
    assign eof_quick = !primed_reg || (cur_size_reg == '0) || (prev_size_reg == '0);
    assign out_load  = (eof_acc && eof_quick) || (state_reg == ST_FIN);
    assign quick_count = primed_reg ? count_reg : COUNT_W'(cur_size_reg);

    assign trial     = root_reg + bit_reg;
    assign trial_ge  = (rad_reg >= trial);
    assign last_c    = ({1'b0, c_reg} + SIZE_W'(1)) == cur_size_reg;
    assign last_p    = ({1'b0, p_reg} + SIZE_W'(1)) == prev_size_reg;
    assign pair_dist = DIST_W'(root_reg[ROOT_W-1:0]) + DIST_W'(df_reg);
    assign new_key   = {pair_dist, p_reg, c_reg};

    assign sort_ctl.ins = (state_reg == ST_INS);
    assign sort_ctl.shf = (state_reg == ST_MATCH) && head_vld;

    assign head_d    = head_key[KEY_W-1 -: DIST_W];
    assign head_p    = head_key[2*IDX_W-1:IDX_W];
    assign head_c    = head_key[IDX_W-1:0];
    assign head_skip = used_p_reg[head_p] && used_c_reg[head_c];

    gmoc_sorter u_sorter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sort_ctl),
        .in_key   (new_key),
        .head_key (head_key),
        .head_vld (head_vld)
    );

    // Two banks of the list memory; the current bank becomes the previous one
    // by flipping bank_reg, so no copy is needed at end of frame.
    always_ff @(posedge clk)
    begin
        if (det_acc && room)
        begin
            list_mem[{bank_reg, cur_size_reg[IDX_W-1:0]}] <= s_tdata;
        end
        rd_prev_reg <= list_mem[{~bank_reg, p_reg}];
        rd_cur_reg  <= list_mem[{bank_reg, c_reg}];
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= absdiff(rd_prev_reg[COORD_W-1:0], rd_cur_reg[COORD_W-1:0]);
        dy_reg  <= absdiff(rd_prev_reg[2*COORD_W-1:COORD_W],
                           rd_cur_reg[2*COORD_W-1:COORD_W]);
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        if (state_reg == ST_DIFF)
        begin
            df_reg <= absdiff(rd_prev_reg[3*COORD_W-1:2*COORD_W],
                              rd_cur_reg[3*COORD_W-1:2*COORD_W]);
        end
        if (state_reg == ST_SUM)
        begin
            rad_reg  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            root_reg <= '0;
            bit_reg  <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (state_reg == ST_SQRT)
        begin
            if (trial_ge)
            begin
                rad_reg  <= rad_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (out_load)
        begin
            out_count_reg <= eof_acc ? quick_count : count_reg;
            out_drop_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_reg         <= '0;
            c_reg         <= '0;
            drain_reg     <= '0;
            cur_size_reg  <= '0;
            prev_size_reg <= '0;
            bank_reg      <= 1'b0;
            primed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            used_p_reg    <= '0;
            used_c_reg    <= '0;
            thr_reg       <= THR_RESET;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (det_acc)
                    begin
                        if (room)
                        begin
                            cur_size_reg <= cur_size_reg + SIZE_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    else if (eof_acc)
                    begin
                        if (eof_quick)
                        begin
                            count_reg    <= quick_count;
                            primed_reg   <= 1'b1;
                            cur_size_reg <= '0;
                            ovf_reg      <= 1'b0;
                            if (!primed_reg || (cur_size_reg != '0))
                            begin
                                bank_reg      <= ~bank_reg;
                                prev_size_reg <= cur_size_reg;
                            end
                        end
                        else
                        begin
                            p_reg      <= '0;
                            c_reg      <= '0;
                            used_p_reg <= '0;
                            used_c_reg <= '0;
                            state_reg  <= ST_READ;
                        end
                    end
                end
                ST_READ:  state_reg <= ST_DIFF;
                ST_DIFF:  state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_SQRT;
                ST_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= ST_INS;
                    end
                end
                ST_INS:
                begin
                    if (last_c)
                    begin
                        c_reg <= '0;
                        if (last_p)
                        begin
                            drain_reg <= '0;
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            p_reg     <= p_reg + IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + IDX_W'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_DRAIN:
                begin
                    // Let every key still travelling down the chain settle.
                    drain_reg <= drain_reg + DRAIN_W'(1);
                    if (drain_reg == DRAIN_W'(PAIR_CAP - 1))
                    begin
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH:
                begin
                    if (!head_vld)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (!head_skip)
                    begin
                        used_p_reg[head_p] <= 1'b1;
                        used_c_reg[head_c] <= 1'b1;
                        if ((head_d > DIST_W'(thr_reg)) && (count_reg != '1))
                        begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                    end
                end
                ST_FIN:
                begin
                    bank_reg      <= ~bank_reg;
                    prev_size_reg <= cur_size_reg;
                    cur_size_reg  <= '0;
                    ovf_reg       <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_drop_reg;

    // The result slot must be free whenever a matched frame finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> !out_vld_reg)
        else $error("result slot busy at end of matching");

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_size_reg <= SIZE_W'(MAX_OBJECTS))
        else $error("current list size beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |->
            (({1'b0, p_reg} < prev_size_reg) && ({1'b0, c_reg} < cur_size_reg)))
        else $error("pair index outside the lists");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) && !head_vld |=> (state_reg == ST_FIN))
        else $error("matching pass did not finish on empty chain");

endmodule

`default_nettype wire

// ----- hdl/gmoc_cell.sv -----
// ============================================================================
// gmoc_cell
// One cell of the sorting chain: keeps the smaller key, passes the larger on.
// ============================================================================
`default_nettype none

module gmoc_cell
    import gmoc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire gmoc_ctl_t ctl,
    input  wire gmoc_key_t left_key,
    input  wire logic      left_vld,
    input  wire gmoc_key_t right_key,
    input  wire logic      right_vld,
    output gmoc_key_t      key,
    output logic           vld,
    output gmoc_key_t      pass_key,
    output logic           pass_vld
);

    gmoc_key_t key_reg;
    gmoc_key_t pass_key_reg;
    logic      vld_reg;
    logic      pass_vld_reg;
    logic      take_left;

    // An empty cell or a smaller incoming key takes this place.
    assign take_left = left_vld && (!vld_reg || (left_key < key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else if (ctl.shf)
        begin
            vld_reg      <= right_vld;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            if (take_left)
            begin
                vld_reg <= 1'b1;
            end
            pass_vld_reg <= left_vld && vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shf)
        begin
            key_reg <= right_key;
        end
        else if (take_left)
        begin
            key_reg      <= left_key;
            pass_key_reg <= key_reg;
        end
        else
        begin
            pass_key_reg <= left_key;
        end
    end

    assign key      = key_reg;
    assign vld      = vld_reg;
    assign pass_key = pass_key_reg;
    assign pass_vld = pass_vld_reg;

endmodule

`default_nettype wire

// ----- hdl/gmoc_sorter.sv -----
// ============================================================================
// gmoc_sorter
// Systolic insertion sorter: a row of cells that holds every pair key sorted.
// ============================================================================
`default_nettype none

module gmoc_sorter
    import gmoc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire gmoc_ctl_t ctl,
    input  wire gmoc_key_t in_key,
    output gmoc_key_t      head_key,
    output logic           head_vld
);

    gmoc_key_t key_w  [PAIR_CAP];
    logic      vld_w  [PAIR_CAP];
    gmoc_key_t pkey_w [PAIR_CAP];
    logic      pvld_w [PAIR_CAP];

    genvar g;
    generate
        for (g = 0; g < PAIR_CAP; g++)
        begin : g_cell
            gmoc_key_t lk;
            logic      lv;
            gmoc_key_t rk;
            logic      rv;
            if (g == 0)
            begin : g_first
                assign lk = in_key;
                assign lv = ctl.ins;
            end
            else
            begin : g_mid
                assign lk = pkey_w[g-1];
                assign lv = pvld_w[g-1];
            end
            if (g == PAIR_CAP - 1)
            begin : g_last
                assign rk = '0;
                assign rv = 1'b0;
            end
            else
            begin : g_inner
                assign rk = key_w[g+1];
                assign rv = vld_w[g+1];
            end
            gmoc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .left_key  (lk),
                .left_vld  (lv),
                .right_key (rk),
                .right_vld (rv),
                .key       (key_w[g]),
                .vld       (vld_w[g]),
                .pass_key  (pkey_w[g]),
                .pass_vld  (pvld_w[g])
            );
        end
    endgenerate

    assign head_key = key_w[0];
    assign head_vld = vld_w[0];

endmodule

`default_nettype wire
